// ===== sv/indexed_double_ended_queue_macros.svh =====
// Assertion macros for the indexed double-ended queue.
// IDQ_ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// IDQ_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define IDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define IDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IDQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/idq_pkg.sv =====
`timescale 1ns / 1ps

package idq_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK   = 3'd0,
		MODE_PUSH_FRONT  = 3'd1,
		MODE_POP_BACK    = 3'd2,
		MODE_POP_FRONT   = 3'd3,
		MODE_READ_INDEX  = 3'd4,
		MODE_WRITE_INDEX = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic        [2:0]  mode;
		logic signed [15:0] index;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic        [1:0]  status;
		logic        [4:0]  occupancy;
	} rsp_t;

endpackage

// ===== sv/idq_ram.sv =====
`timescale 1ns / 1ps

module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/indexed_double_ended_queue.sv =====
// Indexed double-ended queue: a ring of idq_pkg::DEPTH signed 32-bit words with
// push and pop at either end plus read and write by index from the front. A command
// word is taken on any cycle with start high (busy stays low, so a command may be
// issued every cycle); its result word appears on result for exactly one cycle with
// done high, the cycle after acceptance, and must be captured then as it cannot be
// held off. The result word comes from the registered read of the entry RAM; front
// pointer and count update at acceptance, so back-to-back commands see each other.
// Failed commands (empty, index out of range, full) leave the state alone and return 0.
`timescale 1ns / 1ps
`include "indexed_double_ended_queue_macros.svh"

module indexed_double_ended_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  idq_pkg::cmd_t cmd,
	output logic          done,
	output idq_pkg::rsp_t result
);

	localparam int AW = idq_pkg::AW;
	localparam int CW = idq_pkg::CW;
	localparam int DW = idq_pkg::DW;

	logic          accept;
	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic          full, empty, idx_ok;
	logic [AW-1:0] back_slot, last_slot, idx_slot, front_dec;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] rdata;
	idq_pkg::status_t status_d;

	logic             valid_s1;
	logic             rd_s1;
	idq_pkg::status_t status_s1;

	// every access is a single registered RAM access and write-then-read sees new data
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign full      = (count_q == CW'(idq_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign idx_ok    = !cmd.index[15] && (16'(cmd.index) < 16'(count_q));
	assign back_slot = front_q + count_q[AW-1:0];
	assign last_slot = back_slot - AW'(1);
	assign idx_slot  = front_q + cmd.index[AW-1:0];
	assign front_dec = front_q - AW'(1);

	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		waddr    = back_slot;
		raddr    = front_q;
		front_d  = front_q;
		count_d  = count_q;
		status_d = idq_pkg::STATUS_OK;
		case (cmd.mode)
			idq_pkg::MODE_PUSH_BACK: begin
				if (full) begin
					status_d = idq_pkg::STATUS_FULL;
				end else begin
					we      = 1'b1;
					waddr   = back_slot;
					count_d = count_q + CW'(1);
				end
			end
			idq_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					status_d = idq_pkg::STATUS_FULL;
				end else begin
					we      = 1'b1;
					waddr   = front_dec;
					front_d = front_dec;
					count_d = count_q + CW'(1);
				end
			end
			idq_pkg::MODE_POP_BACK: begin
				if (empty) begin
					status_d = idq_pkg::STATUS_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = last_slot;
					count_d = count_q - CW'(1);
				end
			end
			idq_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					status_d = idq_pkg::STATUS_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = front_q;
					front_d = front_q + AW'(1);
					count_d = count_q - CW'(1);
				end
			end
			idq_pkg::MODE_READ_INDEX: begin
				if (!idx_ok) begin
					status_d = idq_pkg::STATUS_RANGE;
				end else begin
					re    = 1'b1;
					raddr = idx_slot;
				end
			end
			idq_pkg::MODE_WRITE_INDEX: begin
				if (!idx_ok) begin
					status_d = idq_pkg::STATUS_RANGE;
				end else begin
					we    = 1'b1;
					waddr = idx_slot;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			we = 1'b0;
			re = 1'b0;
		end
	end

	idq_ram #(
		.WIDTH(DW),
		.DEPTH(idq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(cmd.value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			valid_s1  <= 1'b0;
			rd_s1     <= 1'b0;
			status_s1 <= idq_pkg::STATUS_OK;
		end else begin
			valid_s1 <= accept;
			rd_s1    <= re;
			if (accept) begin
				front_q   <= front_d;
				count_q   <= count_d;
				status_s1 <= status_d;
			end
		end
	end

	// count_q already holds the post-operation value while the result is shown
	assign done             = valid_s1;
	assign result.data      = rd_s1 ? rdata : '0;
	assign result.status    = status_s1;
	assign result.occupancy = 5'(count_q);

	`IDQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(idq_pkg::DEPTH))
	`IDQ_ASSERT_NEXT(a_done_follows, clk, arst_n, accept, done)
	`IDQ_ASSERT_NOW(a_full_status, clk, arst_n, done && result.status == idq_pkg::STATUS_FULL, count_q == CW'(idq_pkg::DEPTH))
	`IDQ_ASSERT_NEXT(a_pop_dec, clk, arst_n, accept && !empty && (cmd.mode == idq_pkg::MODE_POP_BACK || cmd.mode == idq_pkg::MODE_POP_FRONT), count_q == $past(count_q) - CW'(1))

endmodule
